@@ rtl/grs_pkg.sv @@
// Shared types and constants for the grid range sum tree.
// Used by the control sequencer and the top level.
`timescale 1ns / 1ps

package grs_pkg;

  localparam int unsigned BOUND_W = 6;
  localparam int unsigned DATA_W  = 32;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [BOUND_W-1:0]        row_lo;
    logic [BOUND_W-1:0]        row_hi;
    logic [BOUND_W-1:0]        col_lo;
    logic [BOUND_W-1:0]        col_hi;
    logic signed [DATA_W-1:0]  value;
  } grs_req_t;

  typedef struct packed {
    logic                      valid;
    logic signed [DATA_W-1:0]  sum;
  } grs_res_t;

  typedef enum logic [7:0] {
    S_CLR     = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_UPD_RDA = 8'b0000_0100,
    S_UPD_RDB = 8'b0000_1000,
    S_UPD_WR  = 8'b0001_0000,
    S_Q_ROW   = 8'b0010_0000,
    S_Q_COL   = 8'b0100_0000,
    S_Q_DONE  = 8'b1000_0000
  } grs_state_t;

endpackage

@@ rtl/grs_in_if.sv @@
// Request channel: valid/ready handshake with set or query payload.
// No dependencies.
`timescale 1ns / 1ps

interface grs_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [5:0]         row_lo;
  logic [5:0]         row_hi;
  logic [5:0]         col_lo;
  logic [5:0]         col_hi;
  logic signed [31:0] value;

  modport source (output valid, op, row_lo, row_hi, col_lo, col_hi, value, input ready);
  modport sink   (input valid, op, row_lo, row_hi, col_lo, col_hi, value, output ready);
endinterface

@@ rtl/grs_out_if.sv @@
// Result channel: valid/ready handshake carrying one rectangle sum.
// No dependencies.
`timescale 1ns / 1ps

interface grs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sum;

  modport source (output valid, sum, input ready);
  modport sink   (input valid, sum, output ready);
endinterface

@@ rtl/grs_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module grs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/grs_ctrl.sv @@
// Sequencer for the tree: clearing pass, leaf update walk and rectangle query walk.
// Depends on grs_pkg; drives the ports of one grs_ram.
`timescale 1ns / 1ps

module grs_ctrl import grs_pkg::*; #(
  parameter int unsigned SIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  grs_req_t                           req,
  input  logic                               res_ready,
  output grs_res_t                           res,
  output logic                               ram_wr_en,
  output logic [2*$clog2(2*SIDE)-1:0]        ram_wr_addr,
  output logic [DATA_W-1:0]                  ram_wr_data,
  output logic                               ram_rd_en,
  output logic [2*$clog2(2*SIDE)-1:0]        ram_rd_addr,
  input  logic [DATA_W-1:0]                  ram_rd_data
);

  localparam int unsigned CW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned RW = $clog2(2*SIDE);
  localparam int unsigned AW = 2*RW;

  grs_state_t       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [RW-1:0]    lr_r, lr_nxt, lc_r, lc_nxt;
  logic [RW-1:0]    r_r, r_nxt, c_r, c_nxt;
  logic             horiz_r, horiz_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [RW-1:0]    rp_r, rp_nxt, rq_r, rq_nxt;
  logic [RW-1:0]    cp_r, cp_nxt, cq_r, cq_nxt;
  logic [RW-1:0]    cl_r, cl_nxt, ch_r, ch_nxt;
  logic [RW-1:0]    rnode_r, rnode_nxt;
  logic             rsel_r, rsel_nxt, csel_r, csel_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic             pend_r;

  logic [CW-1:0]    qa, qb, qc, qd;
  logic [RW:0]      rp_inc, cp_inc;
  logic [RW-1:0]    rq_dec, cq_dec;
  logic [AW-1:0]    upd_a_addr, upd_b_addr;

  function automatic logic [CW-1:0] clamp_idx(input logic [BOUND_W-1:0] x);
    if (32'(x) >= SIDE) begin
      return CW'(SIDE - 1);
    end
    return CW'(x);
  endfunction

  assign qa = clamp_idx(req.row_lo);
  assign qb = clamp_idx(req.row_hi);
  assign qc = clamp_idx(req.col_lo);
  assign qd = clamp_idx(req.col_hi);

  assign rp_inc = {1'b0, rp_r} + (RW+1)'(1);
  assign cp_inc = {1'b0, cp_r} + (RW+1)'(1);
  assign rq_dec = rq_r - RW'(1);
  assign cq_dec = cq_r - RW'(1);

  assign upd_a_addr = horiz_r ? {r_r, c_r[RW-2:0], 1'b0} : {r_r[RW-2:0], 1'b0, c_r};
  assign upd_b_addr = horiz_r ? {r_r, c_r[RW-2:0], 1'b1} : {r_r[RW-2:0], 1'b1, c_r};

  assign req_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    lr_nxt      = lr_r;
    lc_nxt      = lc_r;
    r_nxt       = r_r;
    c_nxt       = c_r;
    horiz_nxt   = horiz_r;
    a_nxt       = a_r;
    rp_nxt      = rp_r;
    rq_nxt      = rq_r;
    cp_nxt      = cp_r;
    cq_nxt      = cq_r;
    cl_nxt      = cl_r;
    ch_nxt      = ch_r;
    rnode_nxt   = rnode_r;
    rsel_nxt    = rsel_r;
    csel_nxt    = csel_r;
    acc_nxt     = pend_r ? acc_r + ram_rd_data : acc_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = {r_r, c_r};
    ram_wr_data = a_r + ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = upd_a_addr;
    res.valid   = 1'b0;
    res.sum     = acc_r;

    unique case (state_r)
      S_CLR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        ram_wr_data = '0;
        clr_nxt     = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req.op == OP_SET) begin
            if (32'(req.row_lo) < SIDE && 32'(req.col_lo) < SIDE) begin
              lr_nxt      = RW'(SIDE) + RW'(req.row_lo);
              lc_nxt      = RW'(SIDE) + RW'(req.col_lo);
              ram_wr_en   = 1'b1;
              ram_wr_addr = {lr_nxt, lc_nxt};
              ram_wr_data = req.value;
              r_nxt       = lr_nxt;
              c_nxt       = lc_nxt >> 1;
              horiz_nxt   = 1'b1;
              state_nxt   = S_UPD_RDA;
            end
          end else begin
            acc_nxt = '0;
            if (qa > qb || qc > qd) begin
              state_nxt = S_Q_DONE;
            end else begin
              rp_nxt    = RW'(SIDE) + RW'(qa);
              rq_nxt    = RW'(SIDE) + RW'(qb);
              cl_nxt    = RW'(SIDE) + RW'(qc);
              ch_nxt    = RW'(SIDE) + RW'(qd);
              rsel_nxt  = 1'b0;
              state_nxt = S_Q_ROW;
            end
          end
        end
      end
      S_UPD_RDA: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = upd_a_addr;
        state_nxt   = S_UPD_RDB;
      end
      S_UPD_RDB: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = upd_b_addr;
        a_nxt       = ram_rd_data;
        state_nxt   = S_UPD_WR;
      end
      S_UPD_WR: begin
        ram_wr_en = 1'b1;
        state_nxt = S_UPD_RDA;
        priority if ((c_r >> 1) != '0) begin
          c_nxt = c_r >> 1;
        end else if (horiz_r) begin
          horiz_nxt = 1'b0;
          r_nxt     = lr_r >> 1;
          c_nxt     = lc_r;
        end else if ((r_r >> 1) != '0) begin
          r_nxt = r_r >> 1;
          c_nxt = lc_r;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_ROW: begin
        priority if (rp_r > rq_r) begin
          state_nxt = S_Q_DONE;
        end else if (!rsel_r) begin
          rsel_nxt = 1'b1;
          if (rp_r[0]) begin
            rnode_nxt = rp_r;
            cp_nxt    = cl_r;
            cq_nxt    = ch_r;
            csel_nxt  = 1'b0;
            state_nxt = S_Q_COL;
          end
        end else begin
          rsel_nxt = 1'b0;
          rp_nxt   = rp_inc[RW:1];
          rq_nxt   = rq_dec >> 1;
          if (!rq_r[0]) begin
            rnode_nxt = rq_r;
            cp_nxt    = cl_r;
            cq_nxt    = ch_r;
            csel_nxt  = 1'b0;
            state_nxt = S_Q_COL;
          end
        end
      end
      S_Q_COL: begin
        priority if (cp_r > cq_r) begin
          state_nxt = S_Q_ROW;
        end else if (!csel_r) begin
          csel_nxt    = 1'b1;
          ram_rd_en   = cp_r[0];
          ram_rd_addr = {rnode_r, cp_r};
        end else begin
          csel_nxt    = 1'b0;
          ram_rd_en   = !cq_r[0];
          ram_rd_addr = {rnode_r, cq_r};
          cp_nxt      = cp_inc[RW:1];
          cq_nxt      = cq_dec >> 1;
        end
      end
      S_Q_DONE: begin
        if (!pend_r && res_ready) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= ram_rd_en && (state_r == S_Q_COL);
    end
  end

  always_ff @(posedge clk) begin
    lr_r    <= lr_nxt;
    lc_r    <= lc_nxt;
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    horiz_r <= horiz_nxt;
    a_r     <= a_nxt;
    rp_r    <= rp_nxt;
    rq_r    <= rq_nxt;
    cp_r    <= cp_nxt;
    cq_r    <= cq_nxt;
    cl_r    <= cl_nxt;
    ch_r    <= ch_nxt;
    rnode_r <= rnode_nxt;
    rsel_r  <= rsel_nxt;
    csel_r  <= csel_nxt;
    acc_r   <= acc_nxt;
  end

endmodule

@@ rtl/grid_range_sum_tree.sv @@
// Top level of the grid range sum tree: node RAM, sequencer and result register.
// Depends on grs_pkg, grs_in_if, grs_out_if, grs_ram and grs_ctrl.
`timescale 1ns / 1ps
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------------
//  in_chan   | in  | valid / ready | op, row_lo, row_hi, col_lo, col_hi, value
//  out_chan  | out | valid / ready | sum (one per query request)
//
//  With L = log2(SIDE), a set request writes the leaf and then recomputes each
//  ancestor node by reading its first child, reading its second child and writing
//  the sum, on the single read port of the node RAM. A query walks Nr row levels
//  and, for each of K selected row nodes (at most 2*L-2), Nc column levels, Nr and
//  Nc at most L+1; an inverted query goes straight to its result.
//  After reset a clearing pass writes zero to all (2*SIDE)^2 nodes (16384 at
//  SIDE = 64), with in_chan.ready low. A stalled result holds in the output
//  register; the next request is taken meanwhile and a query waits at its end.

module grid_range_sum_tree import grs_pkg::*; #(
  parameter int unsigned SIDE = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  grs_in_if.sink     in_chan,
  grs_out_if.source  out_chan
);

  localparam int unsigned RW    = $clog2(2*SIDE);
  localparam int unsigned AW    = 2*RW;
  localparam int unsigned DEPTH = 2**AW;

  grs_req_t          req;
  grs_res_t          res;
  logic              res_ready;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_sum_r;

  logic              ram_wr_en, ram_rd_en;
  logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
  logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

  assign req.op     = in_chan.op;
  assign req.row_lo = in_chan.row_lo;
  assign req.row_hi = in_chan.row_hi;
  assign req.col_lo = in_chan.col_lo;
  assign req.col_hi = in_chan.col_hi;
  assign req.value  = in_chan.value;

  assign res_ready = !out_valid_r || out_chan.ready;

  grs_ctrl #(
    .SIDE (SIDE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_chan.valid),
    .req_ready   (in_chan.ready),
    .req         (req),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  grs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_sum_r <= res.sum;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.sum   = out_sum_r;

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_chan.ready))
    else $error("result issued while output register is occupied");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_chan.ready)
    else $error("request accepted before clearing pass");

  a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.op == OP_SET) |=> !res.valid)
    else $error("set request produced a result");

endmodule

@@ verif/grid_range_sum_tree_test.sv @@
// Self-checking testbench for grid_range_sum_tree: cell writes and rectangle sums
// under random request gaps and result stalls, checked against a cell-grid model.
// Depends on grs_pkg, grs_in_if, grs_out_if and the grid_range_sum_tree RTL.
`timescale 1ns / 1ps

module grid_range_sum_tree_test;
  import grs_pkg::*;

  localparam int unsigned GRID         = 64;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          QUIET_LIMIT  = 60000;

  class range_sum_board;
    bit [DATA_W-1:0] cells [GRID][GRID];
    bit [DATA_W-1:0] pending_sums [$];
    int              fails;

    function new();
      foreach (cells[r, c]) cells[r][c] = '0;
      fails = 0;
    endfunction

    function automatic int unsigned clamp_bound(logic [BOUND_W-1:0] x);
      return (x >= GRID) ? GRID - 1 : 32'(x);
    endfunction

    function automatic bit [DATA_W-1:0] rect_sum(grs_req_t q);
      int unsigned     rlo, rhi, clo, chi;
      bit [DATA_W-1:0] acc;
      rlo = clamp_bound(q.row_lo);
      rhi = clamp_bound(q.row_hi);
      clo = clamp_bound(q.col_lo);
      chi = clamp_bound(q.col_hi);
      acc = '0;
      if (rlo <= rhi && clo <= chi) begin
        for (int unsigned r = rlo; r <= rhi; r++)
          for (int unsigned c = clo; c <= chi; c++)
            acc += cells[r][c];
      end
      return acc;
    endfunction

    function void note_request(grs_req_t q);
      if (q.op == OP_SET) begin
        if (q.row_lo < GRID && q.col_lo < GRID)
          cells[q.row_lo][q.col_lo] = q.value;
      end else begin
        pending_sums.push_back(rect_sum(q));
      end
    endfunction

    function void check_sum(logic signed [DATA_W-1:0] got);
      bit [DATA_W-1:0] want;
      if (pending_sums.size() == 0) begin
        $error("sum: no result expected, got %0d", got);
        fails++;
      end else begin
        want = pending_sums.pop_front();
        if (got !== want) begin
          $error("sum: expected %0d, got %0d", $signed(want), got);
          fails++;
        end
      end
    endfunction

    function bit waiting();
      return pending_sums.size() != 0;
    endfunction

    function void flag_leftover();
      if (pending_sums.size() != 0) begin
        $error("sum: %0d results never arrived", pending_sums.size());
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   quiet_cycles;
  bit   in_steady;
  bit   out_steady;

  range_sum_board board;

  grs_in_if  in_chan ();
  grs_out_if out_chan ();

  grid_range_sum_tree #(.SIDE(GRID)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // switch between random gaps and back-to-back stretches now and then
  function automatic int pick_gap(ref bit steady);
    if ($urandom_range(0, 29) == 0) steady = !steady;
    return steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic grs_req_t make_req(logic op, int rl, int rh, int cl, int ch,
                                        logic [DATA_W-1:0] v);
    grs_req_t q;
    q.op     = op;
    q.row_lo = BOUND_W'(rl);
    q.row_hi = BOUND_W'(rh);
    q.col_lo = BOUND_W'(cl);
    q.col_hi = BOUND_W'(ch);
    q.value  = v;
    return q;
  endfunction

  function automatic logic [DATA_W-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic grs_req_t random_request();
    grs_req_t         q;
    logic [BOUND_W-1:0] a, b, c, d, t;
    int               kind;
    q.op     = OP_QUERY;
    q.row_lo = BOUND_W'($urandom);
    q.row_hi = BOUND_W'($urandom);
    q.col_lo = BOUND_W'($urandom);
    q.col_hi = BOUND_W'($urandom);
    q.value  = $urandom;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      q.op = OP_SET;
      if ($urandom_range(0, 1)) begin
        q.row_lo = BOUND_W'($urandom_range(0, 15));
        q.col_lo = BOUND_W'($urandom_range(0, 15));
      end
      if ($urandom_range(0, 9) == 0) q.value = extreme_value();
      return q;
    end
    a = BOUND_W'($urandom);
    b = BOUND_W'($urandom);
    c = BOUND_W'($urandom);
    d = BOUND_W'($urandom);
    if (a > b) begin t = a; a = b; b = t; end
    if (c > d) begin t = c; c = d; d = t; end
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      q.row_lo = a; q.row_hi = b; q.col_lo = c; q.col_hi = d;
    end else if (kind < 72) begin
      q.row_lo = BOUND_W'($urandom_range(0, 15));
      q.row_hi = q.row_lo + BOUND_W'($urandom_range(0, 3));
      q.col_lo = BOUND_W'($urandom_range(0, 15));
      q.col_hi = q.col_lo + BOUND_W'($urandom_range(0, 3));
    end else if (kind < 82) begin
      q.row_lo = $urandom_range(0, 1) ? '0 : a;
      q.row_hi = $urandom_range(0, 1) ? BOUND_W'(GRID - 1) : b;
      q.col_lo = $urandom_range(0, 1) ? '0 : c;
      q.col_hi = $urandom_range(0, 1) ? BOUND_W'(GRID - 1) : d;
    end else begin
      // invert rows, columns or both
      kind = $urandom_range(0, 2);
      q.row_lo = a; q.row_hi = b; q.col_lo = c; q.col_hi = d;
      if (kind != 1) begin
        do begin a = BOUND_W'($urandom); b = BOUND_W'($urandom); end while (a == b);
        q.row_lo = (a > b) ? a : b;
        q.row_hi = (a > b) ? b : a;
      end
      if (kind != 0) begin
        do begin c = BOUND_W'($urandom); d = BOUND_W'($urandom); end while (c == d);
        q.col_lo = (c > d) ? c : d;
        q.col_hi = (c > d) ? d : c;
      end
    end
    return q;
  endfunction

  task automatic send_request(input grs_req_t q);
    int gap;
    gap = pick_gap(in_steady);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.op     = q.op;
    in_chan.row_lo = q.row_lo;
    in_chan.row_hi = q.row_hi;
    in_chan.col_lo = q.col_lo;
    in_chan.col_hi = q.col_hi;
    in_chan.value  = q.value;
    in_chan.valid  = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    board.note_request(q);
  endtask

  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (1) begin
      stall = pick_gap(out_steady);
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      board.check_sum(out_chan.sum);
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("grid_range_sum_tree: mismatch");
        $finish;
      end
    end
  end

  initial begin
    grs_req_t directed [$];
    board          = new();
    quiet_cycles   = 0;
    in_steady      = 1'b0;
    out_steady     = 1'b0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.op     = OP_SET;
    in_chan.row_lo = '0;
    in_chan.row_hi = '0;
    in_chan.col_lo = '0;
    in_chan.col_hi = '0;
    in_chan.value  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed.push_back(make_req(OP_QUERY, 0, 63, 0, 63, 0));
    directed.push_back(make_req(OP_SET, 0, 0, 0, 0, 32'h7FFF_FFFF));
    directed.push_back(make_req(OP_SET, 63, 0, 63, 0, 32'h7FFF_FFFF));
    directed.push_back(make_req(OP_QUERY, 0, 63, 0, 63, 0));
    directed.push_back(make_req(OP_SET, 0, 0, 63, 0, 32'h8000_0000));
    directed.push_back(make_req(OP_SET, 63, 0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_SET, 31, 0, 32, 0, 32'h0000_0001));
    directed.push_back(make_req(OP_QUERY, 0, 63, 0, 63, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_QUERY, 63, 63, 63, 63, 0));
    directed.push_back(make_req(OP_QUERY, 0, 0, 0, 0, 0));
    directed.push_back(make_req(OP_QUERY, 63, 0, 0, 63, 0));
    directed.push_back(make_req(OP_QUERY, 0, 63, 63, 0, 0));
    directed.push_back(make_req(OP_QUERY, 40, 39, 20, 19, 0));
    directed.push_back(make_req(OP_QUERY, 0, 0, 0, 63, 0));
    directed.push_back(make_req(OP_QUERY, 0, 63, 63, 63, 0));
    directed.push_back(make_req(OP_QUERY, 1, 62, 1, 62, 0));
    directed.push_back(make_req(OP_QUERY, 31, 31, 32, 32, 0));
    directed.push_back(make_req(OP_SET, 0, 63, 0, 63, 32'h0000_0000));
    directed.push_back(make_req(OP_SET, 31, 63, 32, 63, 32'h8000_0000));
    directed.push_back(make_req(OP_QUERY, 0, 63, 0, 63, 32'h5555_AAAA));
    directed.push_back(make_req(OP_QUERY, 0, 31, 0, 31, 0));
    directed.push_back(make_req(OP_QUERY, 32, 63, 32, 63, 0));
    directed.push_back(make_req(OP_QUERY, 10, 10, 50, 50, 0));
    foreach (directed[i]) send_request(directed[i]);

    repeat (RANDOM_ITEMS) send_request(random_request());

    @(negedge clk);
    in_chan.valid = 1'b0;
    while (board.waiting()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.flag_leftover();
    if (board.fails == 0) begin
      $display("grid_range_sum_tree: match");
    end else begin
      $display("grid_range_sum_tree: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/grs_pkg.sv
rtl/grs_in_if.sv
rtl/grs_out_if.sv
rtl/grs_ram.sv
rtl/grs_ctrl.sv
rtl/grid_range_sum_tree.sv
verif/grid_range_sum_tree_test.sv
